>>> hw/rtl/tets_pkg.sv
// shared types and constants for the tcam edge table search block
// no dependencies; imported by the top level, which is also the only tets_ram user
package tets_pkg;

    localparam int ROWS  = 64;
    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = 7;
    localparam int CTR_W = 32;
    localparam int MASK_W = 64;

    localparam logic [15:0] VTX_WILD = 16'hFFFF;
    localparam logic [8:0]  LAY_WILD = 9'h1FF;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_APPEND     = 2'd1,
        OP_SEARCH_DST = 2'd2,
        OP_SEARCH_VL  = 2'd3
    } op_t;

    typedef struct packed {
        logic [15:0] dst;
        logic [15:0] vertex;
        logic [8:0]  layer;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // one row compare, shared by both search kinds
    function automatic logic row_match(input op_t op, input row_t row, input row_t key);
        logic vm;
        logic lm;
        vm = (row.vertex == key.vertex) || (row.vertex == VTX_WILD);
        lm = (row.layer == key.layer) || (row.layer == LAY_WILD);
        if (op == OP_SEARCH_DST)
        begin
            return row.dst == key.dst;
        end
        return vm && lm;
    endfunction

endpackage

>>> hw/rtl/tets_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tets_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tcam_edge_table_search.sv
// edge table search: a search scans the filled rows in S_SCAN, then moves to S_FINISH;
// clear, append and a search of an empty table go straight to S_FINISH. the next input
// is taken the cycle after the result is loaded into the output register; the result
// waits in S_FINISH while the output register holds a result that out_ready has not taken.
// one row compared per cycle from the row ram.
// reset empties the table and zeroes both totals; row contents are not cleared.
// depends on tets_pkg and tets_ram
module tcam_edge_table_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [15:0]         dest_node,
    input  logic signed [15:0]  vertex,
    input  logic signed [8:0]   layer,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic [5:0]          row_index,
    output logic [63:0]         hit_mask,
    output logic [6:0]          match_count,
    output logic [6:0]          rows_filled,
    output logic [31:0]         search_total,
    output logic [31:0]         hit_total
);
    import tets_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    row_t               key_reg, key_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CTR_W-1:0]   srch_ctr_reg, srch_ctr_next;
    logic [CTR_W-1:0]   hit_ctr_reg, hit_ctr_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]   hits_reg, hits_next;
    logic               full_reg, full_next;
    logic [5:0]         app_idx_reg, app_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic               status_reg;
    logic [5:0]         row_index_reg;
    logic [63:0]        hit_mask_reg;
    logic [6:0]         match_count_reg;
    logic [6:0]         rows_filled_reg;
    logic [31:0]        search_total_reg;
    logic [31:0]        hit_total_reg;

    logic               accept;
    logic               is_full;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    row_t               in_row;
    row_t               ram_rdata;
    logic               hit;
    logic               last_row;
    logic               out_load;

    assign in_row   = '{dst: dest_node, vertex: vertex, layer: layer};
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_full  = (fill_reg >= CNT_W'(ROWS));
    assign ram_we   = accept && (op_t'(op) == OP_APPEND) && !is_full;
    // row 0 is fetched during the transfer cycle, then one row ahead of the compare
    assign ram_raddr = (state_reg == S_SCAN) ? IDX_W'(idx_reg + 1'b1) : '0;

    tets_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(fill_reg)),
        .wdata (in_row),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hit      = row_match(op_reg, ram_rdata, key_reg);
    assign last_row = ((CNT_W'(idx_reg) + 1'b1) == fill_reg);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        srch_ctr_next = srch_ctr_reg;
        hit_ctr_next  = hit_ctr_reg;
        mask_next     = mask_reg;
        hits_next     = hits_reg;
        full_next     = full_reg;
        app_idx_next  = app_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op_t'(op);
                    key_next     = in_row;
                    idx_next     = '0;
                    mask_next    = '0;
                    hits_next    = '0;
                    full_next    = 1'b0;
                    app_idx_next = '0;
                    state_next   = S_FINISH;
                    case (op_t'(op))
                        OP_CLEAR:
                        begin
                            fill_next     = '0;
                            srch_ctr_next = '0;
                            hit_ctr_next  = '0;
                        end
                        OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                app_idx_next = 6'(fill_reg);
                                fill_next    = fill_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (fill_reg == '0)
                            begin
                                srch_ctr_next = srch_ctr_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mask_next = mask_reg | (MASK_W'(hit) << idx_reg);
                hits_next = hits_reg + CNT_W'(hit);
                idx_next  = IDX_W'(idx_reg + 1'b1);
                if (last_row)
                begin
                    srch_ctr_next = srch_ctr_reg + 1'b1;
                    hit_ctr_next  = hit_ctr_reg + CTR_W'(hits_next);
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            srch_ctr_reg  <= '0;
            hit_ctr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            srch_ctr_reg  <= srch_ctr_next;
            hit_ctr_reg   <= hit_ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        mask_reg    <= mask_next;
        hits_reg    <= hits_next;
        full_reg    <= full_next;
        app_idx_reg <= app_idx_next;
        if (out_load)
        begin
            status_reg       <= full_reg;
            row_index_reg    <= app_idx_reg;
            hit_mask_reg     <= mask_reg;
            match_count_reg  <= hits_reg;
            rows_filled_reg  <= fill_reg;
            search_total_reg <= srch_ctr_reg;
            hit_total_reg    <= hit_ctr_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign row_index    = row_index_reg;
    assign hit_mask     = hit_mask_reg;
    assign match_count  = match_count_reg;
    assign rows_filled  = rows_filled_reg;
    assign search_total = search_total_reg;
    assign hit_total    = hit_total_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ROWS))
        else $error("fill count above table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(idx_reg) < fill_reg))
        else $error("scan index past filled rows");

    a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (hits_reg <= CNT_W'(idx_reg)))
        else $error("hit count exceeds rows compared");

    a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> ($countones(mask_reg) == 32'(hits_reg)))
        else $error("hit mask and hit count disagree");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(op) == OP_APPEND) && is_full) |=> full_reg)
        else $error("append to full table not flagged");

endmodule
